// ----- sv/sft_pkg.sv -----
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types, constants and helpers for the slot focus tracker.
// ----------------------------------------------------------------------------
package sft_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
    localparam logic [7:0]       SLOT_LIMIT = 8'(SLOT_COUNT);

    typedef logic [IDX_W-1:0]      slot_idx_t;
    typedef logic [SLOT_COUNT-1:0] slot_map_t;
    typedef logic [CNT_W-1:0]      slot_cnt_t;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_NEXT   = 3'd1,
        CMD_PREV   = 3'd2,
        CMD_LAST   = 3'd3,
        CMD_CLOSE  = 3'd4,
        CMD_SWITCH = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } state_t;

    // scan request: start a cyclic walk from start, looking for an occupied
    // slot, or a free one when want_free is set
    typedef struct packed {
        logic      go;
        logic      up;
        logic      want_free;
        slot_idx_t start;
    } scan_req_t;

    typedef struct packed {
        logic      done;
        logic      found;
        slot_idx_t slot;
    } scan_rsp_t;

    function automatic slot_idx_t slot_inc(input slot_idx_t s);
        return (s == LAST_IDX) ? '0 : s + 1'b1;
    endfunction

    function automatic slot_idx_t slot_dec(input slot_idx_t s);
        return (s == '0) ? LAST_IDX : s - 1'b1;
    endfunction

endpackage

// ----- sv/sft_scan.sv -----
// ----------------------------------------------------------------------------
// sft_scan
// Cyclic slot scanner: tests one slot of the occupancy map per cycle.
// ----------------------------------------------------------------------------
module sft_scan
    import sft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_req_t req,
    input  slot_map_t occ,
    output scan_rsp_t rsp
);

    logic      busy_reg, busy_next;
    slot_idx_t cursor_reg, cursor_next;
    slot_idx_t steps_reg, steps_next;
    logic      up_reg, up_next;
    logic      free_reg, free_next;
    logic      hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        steps_reg  <= steps_next;
        up_reg     <= up_next;
        free_reg   <= free_next;
    end

    always_comb
    begin
        hit         = busy_reg && (occ[cursor_reg] ^ free_reg);
        rsp.done    = busy_reg && (hit || steps_reg == LAST_IDX);
        rsp.found   = hit;
        rsp.slot    = cursor_reg;
        busy_next   = busy_reg;
        cursor_next = cursor_reg;
        steps_next  = steps_reg;
        up_next     = up_reg;
        free_next   = free_reg;
        if (req.go)
        begin
            busy_next   = 1'b1;
            cursor_next = req.start;
            steps_next  = '0;
            up_next     = req.up;
            free_next   = req.want_free;
        end
        else if (busy_reg)
        begin
            if (rsp.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cursor_next = up_reg ? slot_inc(cursor_reg) : slot_dec(cursor_reg);
                steps_next  = steps_reg + 1'b1;
            end
        end
    end

endmodule

// ----- sv/slot_focus_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// slot_focus_tracker_unit
// Occupancy map with active and previous slot tracking, driven by commands.
// ----------------------------------------------------------------------------
// Flow: a command taken in idle is executed, and its result waits in the
// finish state until the output register is free; create, next, previous and
// close of the active slot may first run the scanner over up to SLOT_COUNT slots.
// Throughput: one command at a time; in_ready is high only when idle.
// Reset: all slots free, no active or previous slot, count zero.
module slot_focus_tracker_unit
    import sft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [7:0]  target_slot,
    input  logic        create_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        done_res,
    output logic [3:0]  event_slot,
    output logic        active_valid,
    output logic [3:0]  active_index,
    output logic        previous_valid,
    output logic [3:0]  previous_index,
    output logic [4:0]  open_count,
    output logic [15:0] occupied_bits
);

    state_t    state_reg, state_next;
    slot_map_t occ_reg, occ_next;
    logic      focus_valid_reg, focus_valid_next;
    slot_idx_t focus_slot_reg, focus_slot_next;
    logic      prior_valid_reg, prior_valid_next;
    slot_idx_t prior_slot_reg, prior_slot_next;
    slot_cnt_t open_reg, open_next;

    cmd_t      cmd_reg, cmd_next;
    logic [7:0] tgt_reg, tgt_next;
    logic      ok_reg, ok_next;
    logic      done_reg, done_next;
    slot_idx_t ev_reg, ev_next;

    logic       out_valid_reg, out_valid_next;
    logic       o_done_reg;
    logic [3:0] o_ev_reg;
    logic       o_av_reg;
    logic [3:0] o_ai_reg;
    logic       o_pv_reg;
    logic [3:0] o_pi_reg;
    logic [4:0] o_cnt_reg;
    logic [15:0] o_occ_reg;
    logic       load_out;

    scan_req_t scan_req;
    scan_rsp_t scan_rsp;

    slot_idx_t tgt_idx;
    logic      tgt_occ;
    logic      prior_occ;

    sft_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .occ   (occ_reg),
        .rsp   (scan_rsp)
    );

    assign tgt_idx   = tgt_reg[IDX_W-1:0];
    assign tgt_occ   = (tgt_reg < SLOT_LIMIT) && occ_reg[tgt_idx];
    assign prior_occ = prior_valid_reg && occ_reg[prior_slot_reg];

    assign in_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            occ_reg         <= '0;
            focus_valid_reg <= 1'b0;
            focus_slot_reg  <= '0;
            prior_valid_reg <= 1'b0;
            prior_slot_reg  <= '0;
            open_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            occ_reg         <= occ_next;
            focus_valid_reg <= focus_valid_next;
            focus_slot_reg  <= focus_slot_next;
            prior_valid_reg <= prior_valid_next;
            prior_slot_reg  <= prior_slot_next;
            open_reg        <= open_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tgt_reg  <= tgt_next;
        ok_reg   <= ok_next;
        done_reg <= done_next;
        ev_reg   <= ev_next;
        if (load_out)
        begin
            o_done_reg <= done_reg;
            o_ev_reg   <= 4'(ev_reg);
            o_av_reg   <= focus_valid_reg;
            o_ai_reg   <= focus_valid_reg ? 4'(focus_slot_reg) : 4'd0;
            o_pv_reg   <= prior_valid_reg;
            o_pi_reg   <= prior_valid_reg ? 4'(prior_slot_reg) : 4'd0;
            o_cnt_reg  <= 5'(open_reg);
            o_occ_reg  <= 16'(occ_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        focus_valid_next = focus_valid_reg;
        focus_slot_next  = focus_slot_reg;
        prior_valid_next = prior_valid_reg;
        prior_slot_next  = prior_slot_reg;
        open_next        = open_reg;
        cmd_next         = cmd_reg;
        tgt_next         = tgt_reg;
        ok_next          = ok_reg;
        done_next        = done_reg;
        ev_next          = ev_reg;
        scan_req         = '0;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    tgt_next   = target_slot;
                    ok_next    = create_ok;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                done_next  = 1'b0;
                ev_next    = '0;
                state_next = ST_FIN;
                unique case (cmd_reg)
                    CMD_CREATE:
                    begin
                        if (ok_reg)
                        begin
                            scan_req.go        = 1'b1;
                            scan_req.up        = 1'b1;
                            scan_req.want_free = 1'b1;
                            scan_req.start     = '0;
                            state_next         = ST_SCAN;
                        end
                    end
                    CMD_NEXT, CMD_PREV:
                    begin
                        if (open_reg > slot_cnt_t'(1))
                        begin
                            scan_req.go = 1'b1;
                            scan_req.up = (cmd_reg == CMD_NEXT);
                            if (cmd_reg == CMD_NEXT)
                            begin
                                scan_req.start = focus_valid_reg ?
                                                 slot_inc(focus_slot_reg) : '0;
                            end
                            else
                            begin
                                scan_req.start = focus_valid_reg ?
                                                 slot_dec(focus_slot_reg) : LAST_IDX;
                            end
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_LAST:
                    begin
                        if (prior_occ)
                        begin
                            focus_valid_next = 1'b1;
                            focus_slot_next  = prior_slot_reg;
                            prior_valid_next = focus_valid_reg;
                            prior_slot_next  = focus_valid_reg ? focus_slot_reg : '0;
                            done_next        = 1'b1;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        if (tgt_occ)
                        begin
                            occ_next[tgt_idx] = 1'b0;
                            open_next         = open_reg - 1'b1;
                            ev_next           = tgt_idx;
                            done_next         = 1'b1;
                            if (open_reg == slot_cnt_t'(1))
                            begin
                                focus_valid_next = 1'b0;
                                focus_slot_next  = '0;
                            end
                            else if (focus_valid_reg && focus_slot_reg == tgt_idx)
                            begin
                                // previous slot wins if it survives the close
                                if (prior_occ && prior_slot_reg != tgt_idx)
                                begin
                                    focus_slot_next = prior_slot_reg;
                                end
                                else
                                begin
                                    scan_req.go    = 1'b1;
                                    scan_req.up    = 1'b1;
                                    scan_req.start = slot_inc(tgt_idx);
                                    state_next     = ST_SCAN;
                                end
                            end
                        end
                    end
                    CMD_SWITCH:
                    begin
                        if (tgt_occ)
                        begin
                            prior_valid_next = focus_valid_reg;
                            prior_slot_next  = focus_slot_reg;
                            focus_valid_next = 1'b1;
                            focus_slot_next  = tgt_idx;
                            done_next        = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    state_next = ST_FIN;
                    if (cmd_reg == CMD_CLOSE)
                    begin
                        focus_slot_next = scan_rsp.slot;
                    end
                    else if (cmd_reg != CMD_CREATE || scan_rsp.found)
                    begin
                        prior_valid_next = focus_valid_reg;
                        prior_slot_next  = focus_slot_reg;
                        focus_valid_next = 1'b1;
                        focus_slot_next  = scan_rsp.slot;
                        done_next        = 1'b1;
                        if (cmd_reg == CMD_CREATE)
                        begin
                            occ_next[scan_rsp.slot] = 1'b1;
                            open_next               = open_reg + 1'b1;
                            ev_next                 = scan_rsp.slot;
                        end
                    end
                end
            end

            ST_FIN:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign done_res       = o_done_reg;
    assign event_slot     = o_ev_reg;
    assign active_valid   = o_av_reg;
    assign active_index   = o_ai_reg;
    assign previous_valid = o_pv_reg;
    assign previous_index = o_pi_reg;
    assign open_count     = o_cnt_reg;
    assign occupied_bits  = o_occ_reg;

    // count tracks the map
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(open_reg) == $countones(occ_reg))
        else $error("open count disagrees with occupancy map");

    // an active slot is always an occupied one between commands
    a_focus_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && focus_valid_reg) |-> occ_reg[focus_slot_reg])
        else $error("active slot is not occupied");

    // a successful create leaves focus on the slot it took
    a_create_focus: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && done_reg && cmd_reg == CMD_CREATE) |->
            (occ_reg[ev_reg] && focus_valid_reg && focus_slot_reg == ev_reg))
        else $error("create did not focus the allocated slot");

    // the scanner is never restarted mid-walk
    a_scan_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        scan_req.go |-> (state_reg == ST_EXEC && !scan_rsp.done))
        else $error("scan started while scanner busy");

endmodule
